/* design/aens_pkg.sv */
// ----------------------------------------------------------------------------
// Archive entry name check - shared definitions
// Character codes, verdict codes, the per-step item type and the helper
// functions that classify bytes and recognise reserved device stems.
// ----------------------------------------------------------------------------
package aens_pkg;

  // Verdict codes carried on the result channel.
  localparam logic [1:0] VERDICT_SAFE    = 2'd0;
  localparam logic [1:0] VERDICT_CONTROL = 2'd1;
  localparam logic [1:0] VERDICT_UNSAFE  = 2'd2;

  // Character codes used by the path rules.
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_PIPE      = 8'h7C;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] CH_DIGIT_1   = 8'h31;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Stem bookkeeping: four stored bytes, length saturating at five.
  localparam int STEM_BYTES = 4;
  localparam logic [2:0] STEM_LEN_MAX = 3'd5;
  localparam logic [2:0] STEM_LEN_FULL = 3'd4;
  localparam logic [2:0] STEM_LEN_THREE = 3'd3;
  localparam logic [1:0] SEEN_MAX = 2'd2;

  typedef logic [STEM_BYTES-1:0][7:0] stem_t;

  // One transaction of the input channel.
  typedef struct packed {
    logic [7:0] name_char;
    logic       char_present;
    logic       last_char;
  } item_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic is_control(input logic [7:0] c);
    is_control = (c < CH_SPACE) || (c == CH_DEL);
  endfunction

  function automatic logic is_bad_char(input logic [7:0] c);
    is_bad_char = (c == CH_BACKSLASH) || (c == CH_LT) || (c == CH_GT) ||
                  (c == CH_COLON) || (c == CH_QUOTE) || (c == CH_PIPE) ||
                  (c == CH_QUESTION) || (c == CH_STAR);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      to_upper = c - CASE_OFFSET;
    end else begin
      to_upper = c;
    end
  endfunction

  // True when the stem spells a reserved device name.
  function automatic logic stem_reserved(input logic [2:0] len, input stem_t s);
    logic [23:0] w;
    logic        num_ok;
    w = {s[0], s[1], s[2]};
    num_ok = (s[3] >= CH_DIGIT_1) && (s[3] <= CH_DIGIT_9);
    if (len == STEM_LEN_THREE) begin
      stem_reserved = (w == "CON") || (w == "PRN") || (w == "AUX") || (w == "NUL");
    end else if (len == STEM_LEN_FULL) begin
      stem_reserved = ((w == "COM") || (w == "LPT")) && num_ok;
    end else begin
      stem_reserved = 1'b0;
    end
  endfunction

  // Judgement of a finished, non-empty segment.
  function automatic logic segment_bad(input logic [7:0] prev, input logic [2:0] len,
                                       input stem_t s);
    segment_bad = (prev == CH_DOT) || (prev == CH_SPACE) || stem_reserved(len, s);
  endfunction

endpackage

/* design/archive_entry_name_safety_check.sv */
// ----------------------------------------------------------------------------
// Archive entry name safety check
// Streams an archive entry name one byte per transaction and returns one
// verdict per name: safe, control character present, or unsafe path.
//
//   Channel  Ports                                          Direction
//   input    in_valid/in_ready, in_name_char,               in
//            in_char_present, in_last_char
//   result   out_valid/out_ready, out_verdict               out
//
// One byte per cycle is taken unless a marked byte is held back. A byte goes
// from the input register through the per-name state update into the result
// register, which offers the verdict once the last-byte mark has passed both.
// Reset is synchronous and active low; it empties both registers and clears
// the per-name state. A waiting result holds back only a byte that carries
// the mark; that byte then stays in the input register and stops further
// input until the result is taken. Other bytes keep flowing meanwhile.
// ----------------------------------------------------------------------------
module archive_entry_name_safety_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_name_char,
  input  logic       in_char_present,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict
);

  logic             in_valid_r;
  aens_pkg::item_t  item_r;
  logic             out_valid_r;
  logic [1:0]       verdict_r;
  logic [1:0]       verdict;
  logic             out_free;
  logic             step_go;

  // A byte advances unless it ends a name and the result slot is occupied.
  assign out_free = !out_valid_r || out_ready;
  assign step_go  = in_valid_r && (!item_r.last_char || out_free);
  assign in_ready = !in_valid_r || step_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.name_char    <= in_name_char;
      item_r.char_present <= in_char_present;
      item_r.last_char    <= in_last_char;
    end
  end

  // Per-name state and verdict logic.
  aens_name_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_go),
    .item    (item_r),
    .verdict (verdict)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go && item_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && item_r.last_char) begin
      verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule

/* design/aens_name_state.sv */
// ----------------------------------------------------------------------------
// Archive entry name check - per-name state
// Holds the running findings for the name in progress, updates them with one
// byte per step and forms the verdict on the step that ends the name.
// ----------------------------------------------------------------------------
module aens_name_state (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  aens_pkg::item_t    item,
  output logic [1:0]         verdict
);

  logic [1:0]          seen_r, seen_nxt;
  logic                first_letter_r, first_letter_nxt;
  logic                ctrl_r, ctrl_nxt;
  logic                unsafe_r, unsafe_nxt;
  logic                seg_ne_r, seg_ne_nxt;
  logic [2:0]          stem_len_r, stem_len_nxt;
  aens_pkg::stem_t     stem_r, stem_nxt;
  logic                dot_r, dot_nxt;
  logic [7:0]          prev_r, prev_nxt;

  logic [7:0]          c;
  logic                unsafe_fin;

  assign c = item.name_char;

  // Next state for one byte of the name.
  always_comb begin
    seen_nxt         = seen_r;
    first_letter_nxt = first_letter_r;
    ctrl_nxt         = ctrl_r;
    unsafe_nxt       = unsafe_r;
    seg_ne_nxt       = seg_ne_r;
    stem_len_nxt     = stem_len_r;
    stem_nxt         = stem_r;
    dot_nxt          = dot_r;
    prev_nxt         = prev_r;
    if (item.char_present) begin
      if (aens_pkg::is_control(c)) begin
        ctrl_nxt = 1'b1;
      end
      if (aens_pkg::is_bad_char(c)) begin
        unsafe_nxt = 1'b1;
      end
      if (seen_r == 2'd0) begin
        first_letter_nxt = aens_pkg::is_letter(c);
        if (c == aens_pkg::CH_SLASH) begin
          unsafe_nxt = 1'b1;
        end
      end else if (seen_r == 2'd1 && first_letter_r && c == aens_pkg::CH_COLON) begin
        unsafe_nxt = 1'b1;
      end
      if (c == aens_pkg::CH_SLASH) begin
        // Segment ends here: judge it, then start a fresh one.
        if (!seg_ne_r || aens_pkg::segment_bad(prev_r, stem_len_r, stem_r)) begin
          unsafe_nxt = 1'b1;
        end
        seg_ne_nxt   = 1'b0;
        stem_len_nxt = 3'd0;
        stem_nxt     = '0;
        dot_nxt      = 1'b0;
      end else begin
        seg_ne_nxt = 1'b1;
        if (!dot_r) begin
          if (c == aens_pkg::CH_DOT) begin
            dot_nxt = 1'b1;
          end else begin
            if (stem_len_r < aens_pkg::STEM_LEN_FULL) begin
              stem_nxt[stem_len_r[1:0]] = aens_pkg::to_upper(c);
            end
            if (stem_len_r < aens_pkg::STEM_LEN_MAX) begin
              stem_len_nxt = stem_len_r + 3'd1;
            end
          end
        end
      end
      prev_nxt = c;
      if (seen_r < aens_pkg::SEEN_MAX) begin
        seen_nxt = seen_r + 2'd1;
      end
    end
  end

  // Closing judgement for the step that carries the last-byte mark.
  always_comb begin
    unsafe_fin = unsafe_nxt;
    if (seg_ne_nxt) begin
      if (aens_pkg::segment_bad(prev_nxt, stem_len_nxt, stem_nxt)) begin
        unsafe_fin = 1'b1;
      end
    end else if (seen_nxt == 2'd0) begin
      unsafe_fin = 1'b1;
    end
    if (ctrl_nxt) begin
      verdict = aens_pkg::VERDICT_CONTROL;
    end else if (unsafe_fin) begin
      verdict = aens_pkg::VERDICT_UNSAFE;
    end else begin
      verdict = aens_pkg::VERDICT_SAFE;
    end
  end

  // State registers: cleared after every verdict.
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && item.last_char)) begin
      seen_r         <= 2'd0;
      first_letter_r <= 1'b0;
      ctrl_r         <= 1'b0;
      unsafe_r       <= 1'b0;
      seg_ne_r       <= 1'b0;
      stem_len_r     <= 3'd0;
      stem_r         <= '0;
      dot_r          <= 1'b0;
      prev_r         <= 8'd0;
    end else if (step_en) begin
      seen_r         <= seen_nxt;
      first_letter_r <= first_letter_nxt;
      ctrl_r         <= ctrl_nxt;
      unsafe_r       <= unsafe_nxt;
      seg_ne_r       <= seg_ne_nxt;
      stem_len_r     <= stem_len_nxt;
      stem_r         <= stem_nxt;
      dot_r          <= dot_nxt;
      prev_r         <= prev_nxt;
    end
  end

endmodule
